// ----- src/pld_pkg.sv -----
package pld_pkg;

  // Result kinds
  localparam logic [1:0] KIND_INT     = 2'd0;
  localparam logic [1:0] KIND_STR_HDR = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  // Encoding byte values
  localparam logic [7:0] ENC_INT8  = 8'hfe;
  localparam logic [7:0] ENC_INT16 = 8'hc0;
  localparam logic [7:0] ENC_INT24 = 8'hf0;
  localparam logic [7:0] ENC_INT32 = 8'hd0;
  localparam logic [7:0] ENC_INT64 = 8'he0;
  localparam logic [7:0] END_MARK  = 8'hff;
  localparam logic [7:0] PREV_LONG = 8'd254;

  localparam logic [15:0] COUNT_MAX  = 16'hffff;
  localparam logic [15:0] COUNT_SAT  = 16'd65534;
  localparam logic [3:0]  HDR_BYTES  = 4'd10;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [63:0] int_value;
    logic [31:0]        str_length;
    logic [7:0]         payload_byte;
    logic               last_of_string;
    logic [15:0]        entry_count;
    logic               count_error;
  } pld_result_t;

  // Content bytes of a fixed-width integer encoding, zero if not one.
  function automatic logic [3:0] int_bytes(input logic [7:0] enc);
    logic [3:0] n;
    begin
      unique case (enc)
        ENC_INT8:  n = 4'd1;
        ENC_INT16: n = 4'd2;
        ENC_INT24: n = 4'd3;
        ENC_INT32: n = 4'd4;
        ENC_INT64: n = 4'd8;
        default:   n = 4'd0;
      endcase
      return n;
    end
  endfunction

endpackage

// ----- src/pld_parser.sv -----
module pld_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_valid,
  input  logic [7:0]          data_byte,
  input  logic                start_req,
  output logic                res_valid,
  output pld_pkg::pld_result_t res
);
  import pld_pkg::*;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_HEADER   = 3'd1;
  localparam logic [2:0] PH_PREV     = 3'd2;
  localparam logic [2:0] PH_PREVLONG = 3'd3;
  localparam logic [2:0] PH_ENC      = 3'd4;
  localparam logic [2:0] PH_INT      = 3'd5;
  localparam logic [2:0] PH_SLEN     = 3'd6;
  localparam logic [2:0] PH_PAYLOAD  = 3'd7;

  logic [2:0]  phase_r, phase_cur, phase_nxt;
  logic [3:0]  cnt_r, cnt_cur, cnt_nxt;
  logic [15:0] dcnt_r, dcnt_cur, dcnt_nxt;
  logic [7:0]  enc_r, enc_cur, enc_nxt;
  logic [63:0] acc_r, acc_cur, acc_nxt;
  logic [31:0] rem_r, rem_cur, rem_nxt;
  logic [15:0] seen_r, seen_cur, seen_nxt;

  logic        emit;
  pld_result_t r;
  logic [3:0]  n;
  logic [3:0]  cnt_inc;
  logic [3:0]  cnt_dec;
  logic [31:0] rem_dec;
  logic [63:0] v;
  logic [31:0] slen;

  always_comb begin
    phase_cur = phase_r;
    cnt_cur   = cnt_r;
    dcnt_cur  = dcnt_r;
    enc_cur   = enc_r;
    acc_cur   = acc_r;
    rem_cur   = rem_r;
    seen_cur  = seen_r;
    // restart from any phase
    if (start_req) begin
      phase_cur = PH_HEADER;
      cnt_cur   = '0;
      dcnt_cur  = '0;
      enc_cur   = '0;
      acc_cur   = '0;
      rem_cur   = '0;
      seen_cur  = '0;
    end

    phase_nxt = phase_cur;
    cnt_nxt   = cnt_cur;
    dcnt_nxt  = dcnt_cur;
    enc_nxt   = enc_cur;
    acc_nxt   = acc_cur;
    rem_nxt   = rem_cur;
    seen_nxt  = seen_cur;
    emit      = 1'b0;
    r         = '0;
    n         = int_bytes(enc_cur);
    cnt_inc   = cnt_cur + 4'd1;
    cnt_dec   = cnt_cur - 4'd1;
    rem_dec   = rem_cur - 32'd1;
    v         = '0;
    slen      = '0;

    unique case (phase_cur)
      PH_HEADER: begin
        if (cnt_cur == 4'd8) dcnt_nxt[7:0] = data_byte;
        else if (cnt_cur == 4'd9) dcnt_nxt[15:8] = data_byte;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= HDR_BYTES) begin
          cnt_nxt   = '0;
          phase_nxt = PH_PREV;
        end
      end
      PH_PREV: begin
        if (data_byte == END_MARK) begin
          phase_nxt     = PH_IDLE;
          emit          = 1'b1;
          r.kind        = KIND_END;
          r.entry_count = seen_cur;
          r.count_error = (seen_cur < COUNT_SAT) && (seen_cur != dcnt_cur);
        end else if (data_byte >= PREV_LONG) begin
          cnt_nxt   = 4'd4;
          phase_nxt = PH_PREVLONG;
        end else begin
          phase_nxt = PH_ENC;
        end
      end
      PH_PREVLONG: begin
        cnt_nxt = cnt_dec;
        if (cnt_dec == 4'd0) phase_nxt = PH_ENC;
      end
      PH_ENC: begin
        enc_nxt = data_byte;
        if (seen_cur < COUNT_MAX) seen_nxt = seen_cur + 16'd1;
        acc_nxt = '0;
        cnt_nxt = '0;
        if (int_bytes(data_byte) != 4'd0) begin
          phase_nxt = PH_INT;
        end else begin
          case (data_byte[7:6])
            2'b00: begin
              slen = {26'd0, data_byte[5:0]};
              emit = 1'b1;
            end
            2'b01: begin
              acc_nxt   = {58'd0, data_byte[5:0]};
              cnt_nxt   = 4'd1;
              phase_nxt = PH_SLEN;
            end
            2'b10: begin
              cnt_nxt   = 4'd4;
              phase_nxt = PH_SLEN;
            end
            default: begin
              phase_nxt = PH_PREV;
              emit      = 1'b1;
              r.kind    = KIND_INT;
              if (data_byte[7:4] == 4'hf)
                r.int_value = {60'd0, data_byte[3:0]} - 64'd1;
            end
          endcase
          // string length known at once
          if (data_byte[7:6] == 2'b00) begin
            rem_nxt      = slen;
            phase_nxt    = (slen != 32'd0) ? PH_PAYLOAD : PH_PREV;
            r.kind       = KIND_STR_HDR;
            r.str_length = slen;
          end
        end
      end
      PH_INT: begin
        if (n == 4'd0 || cnt_cur >= 4'd8) begin
          phase_nxt = PH_PREV;
        end else begin
          acc_nxt = acc_cur | ({56'd0, data_byte} << {cnt_cur[2:0], 3'b000});
          cnt_nxt = cnt_inc;
          if (cnt_inc >= n) begin
            unique case (n)
              4'd1:    v = {{56{acc_nxt[7]}},  acc_nxt[7:0]};
              4'd2:    v = {{48{acc_nxt[15]}}, acc_nxt[15:0]};
              4'd3:    v = {{40{acc_nxt[23]}}, acc_nxt[23:0]};
              4'd4:    v = {{32{acc_nxt[31]}}, acc_nxt[31:0]};
              default: v = acc_nxt;
            endcase
            cnt_nxt     = '0;
            phase_nxt   = PH_PREV;
            emit        = 1'b1;
            r.kind      = KIND_INT;
            r.int_value = v;
          end
        end
      end
      PH_SLEN: begin
        acc_nxt = {32'd0, acc_cur[23:0], data_byte};
        cnt_nxt = cnt_dec;
        if (cnt_dec == 4'd0) begin
          slen         = acc_nxt[31:0];
          rem_nxt      = slen;
          phase_nxt    = (slen != 32'd0) ? PH_PAYLOAD : PH_PREV;
          emit         = 1'b1;
          r.kind       = KIND_STR_HDR;
          r.str_length = slen;
        end
      end
      PH_PAYLOAD: begin
        rem_nxt = rem_dec;
        if (rem_dec == 32'd0) phase_nxt = PH_PREV;
        emit             = 1'b1;
        r.kind           = KIND_PAYLOAD;
        r.payload_byte   = data_byte;
        r.last_of_string = (rem_cur == 32'd1);
      end
      default: begin
      end
    endcase
  end

  assign res_valid = byte_valid && emit;
  assign res       = r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      dcnt_r  <= '0;
      enc_r   <= '0;
      acc_r   <= '0;
      rem_r   <= '0;
      seen_r  <= '0;
    end else if (byte_valid) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      dcnt_r  <= dcnt_nxt;
      enc_r   <= enc_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
      seen_r  <= seen_nxt;
    end
  end

  a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind == KIND_END |=> phase_r == PH_IDLE)
    else $error("end of list did not return parser to idle");

  a_payload_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> rem_r != 32'd0)
    else $error("payload phase with no bytes left");

endmodule

// ----- src/pld_out_buf.sv -----
module pld_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pld_pkg::pld_result_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output pld_pkg::pld_result_t out_data
);
  import pld_pkg::*;

  pld_result_t main_r, main_nxt;
  pld_result_t skid_r, skid_nxt;
  logic        main_valid_r, main_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  logic        pop;

  assign pop = main_valid_r && !out_stall;

  always_comb begin
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      // input is held off while the skid word waits
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid word held with empty output register");

  a_stalled_push_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    main_valid_r && out_stall && !skid_valid_r && push |=> skid_valid_r)
    else $error("word pushed into a stalled output was lost");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    main_valid_r && !out_stall && !skid_valid_r && !push |=> !main_valid_r)
    else $error("output word repeated after being taken");

endmodule

// ----- src/packed_list_entry_decoder.sv -----
// Packed list entry decoder.
// Input channel: one byte of the packed list per word (in_data_byte), with
// in_start_req set on the first header byte of each list. A word is taken
// at a clock edge where in_valid is high and in_stall is low.
// Result channel: at most one result word per input byte: an integer, a
// string header, a string payload byte or the end-of-list summary. A word
// is delivered at an edge where out_valid is high and out_stall is low.
// Unused fields of a result word read as zero.
// A taken byte's result is registered in the output buffer. Throughput: one
// byte per cycle while in_stall is low; the parse state update for a byte
// is a single pass through the decode logic into the state registers.
// A two-word output buffer (output register plus skid register) sits on
// the result side; in_stall is high exactly while both hold a word, so a
// stalled receiver holds off the input from the cycle after the second
// word is buffered until the receiver takes a word.
// Reset (synchronous, rst_n low) empties the buffer and puts the parser in
// idle; bytes before the first start request are dropped without result.
module packed_list_entry_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_start_req,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic signed [63:0] out_int_value,
  output logic [31:0]        out_str_length,
  output logic [7:0]         out_payload_byte,
  output logic               out_last_of_string,
  output logic [15:0]        out_entry_count,
  output logic               out_count_error
);
  import pld_pkg::*;

  logic        take;
  logic        res_valid;
  logic        full;
  pld_result_t res;
  pld_result_t out_data;

  assign in_stall = full;
  assign take     = in_valid && !full;

  pld_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (take),
    .data_byte  (in_data_byte),
    .start_req  (in_start_req),
    .res_valid  (res_valid),
    .res        (res)
  );

  pld_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_kind           = out_data.kind;
  assign out_int_value      = out_data.int_value;
  assign out_str_length     = out_data.str_length;
  assign out_payload_byte   = out_data.payload_byte;
  assign out_last_of_string = out_data.last_of_string;
  assign out_entry_count    = out_data.entry_count;
  assign out_count_error    = out_data.count_error;

endmodule

// ----- bench/pld_entry_checker.sv -----
module pld_entry_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_start_req,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_kind,
  input  logic signed [63:0] out_int_value,
  input  logic [31:0]        out_str_length,
  input  logic [7:0]         out_payload_byte,
  input  logic               out_last_of_string,
  input  logic [15:0]        out_entry_count,
  input  logic               out_count_error,
  output int                 mismatches,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import pld_pkg::*;

  typedef enum logic [3:0] {
    PARSE_IDLE,
    PARSE_HEADER,
    PARSE_PREV,
    PARSE_PREV_LONG,
    PARSE_ENC,
    PARSE_INT,
    PARSE_STR_LEN,
    PARSE_PAYLOAD
  } parse_phase_t;

  parse_phase_t phase;
  logic [3:0]   byte_cnt;
  logic [15:0]  declared_cnt;
  logic [15:0]  seen_cnt;
  logic [7:0]   enc_byte;
  logic [63:0]  acc;
  logic [31:0]  payload_left;
  pld_result_t  decoded_words[$];

  function automatic logic [3:0] content_len(logic [7:0] enc);
    case (enc)
      ENC_INT8:  return 4'd1;
      ENC_INT16: return 4'd2;
      ENC_INT24: return 4'd3;
      ENC_INT32: return 4'd4;
      ENC_INT64: return 4'd8;
      default:   return 4'd0;
    endcase
  endfunction

  function automatic pld_result_t blank_word(logic [1:0] kind);
    pld_result_t w;
    w = '0;
    w.kind = kind;
    return w;
  endfunction

  task automatic open_string(logic [31:0] len);
    pld_result_t w;
    w = blank_word(KIND_STR_HDR);
    w.str_length = len;
    payload_left = len;
    phase = (len != 32'd0) ? PARSE_PAYLOAD : PARSE_PREV;
    decoded_words.push_back(w);
  endtask

  task automatic decode_byte(logic [7:0] b, logic st);
    pld_result_t w;
    logic [3:0]  n;
    logic [63:0] v;
    if (st) begin
      phase = PARSE_HEADER;
      byte_cnt = 4'd0;
      declared_cnt = 16'd0;
      seen_cnt = 16'd0;
      acc = 64'd0;
      payload_left = 32'd0;
      enc_byte = 8'd0;
    end
    case (phase)
      PARSE_HEADER: begin
        if (byte_cnt == 4'd8) declared_cnt[7:0] = b;
        else if (byte_cnt == 4'd9) declared_cnt[15:8] = b;
        byte_cnt = byte_cnt + 4'd1;
        if (byte_cnt >= HDR_BYTES) begin
          byte_cnt = 4'd0;
          phase = PARSE_PREV;
        end
      end
      PARSE_PREV: begin
        if (b == END_MARK) begin
          w = blank_word(KIND_END);
          w.entry_count = seen_cnt;
          w.count_error = (seen_cnt < COUNT_SAT) && (seen_cnt != declared_cnt);
          phase = PARSE_IDLE;
          decoded_words.push_back(w);
        end else if (b == PREV_LONG) begin
          byte_cnt = 4'd4;
          phase = PARSE_PREV_LONG;
        end else begin
          phase = PARSE_ENC;
        end
      end
      PARSE_PREV_LONG: begin
        byte_cnt = byte_cnt - 4'd1;
        if (byte_cnt == 4'd0) phase = PARSE_ENC;
      end
      PARSE_ENC: begin
        enc_byte = b;
        if (seen_cnt != COUNT_MAX) seen_cnt++;
        acc = 64'd0;
        byte_cnt = 4'd0;
        n = content_len(b);
        if (n != 4'd0) begin
          phase = PARSE_INT;
        end else begin
          case (b[7:6])
            2'b00: open_string({26'd0, b[5:0]});
            2'b01: begin
              acc = {58'd0, b[5:0]};
              byte_cnt = 4'd1;
              phase = PARSE_STR_LEN;
            end
            2'b10: begin
              byte_cnt = 4'd4;
              phase = PARSE_STR_LEN;
            end
            default: begin
              // immediates carry nibble minus one; other 11xxxxxx give zero
              w = blank_word(KIND_INT);
              if (b[7:4] == 4'hf) w.int_value = {60'd0, b[3:0]} - 64'd1;
              phase = PARSE_PREV;
              decoded_words.push_back(w);
            end
          endcase
        end
      end
      PARSE_INT: begin
        n = content_len(enc_byte);
        if (n == 4'd0 || byte_cnt >= 4'd8) begin
          phase = PARSE_PREV;
        end else begin
          acc = acc | ({56'd0, b} << (8 * byte_cnt));
          byte_cnt = byte_cnt + 4'd1;
          if (byte_cnt >= n) begin
            v = acc;
            if (n < 4'd8 && v[8 * n - 1]) v = v | (~64'd0 << (8 * n));
            w = blank_word(KIND_INT);
            w.int_value = v;
            byte_cnt = 4'd0;
            phase = PARSE_PREV;
            decoded_words.push_back(w);
          end
        end
      end
      PARSE_STR_LEN: begin
        // big-endian length, kept to 32 bits
        acc = {32'd0, acc[23:0], b};
        byte_cnt = byte_cnt - 4'd1;
        if (byte_cnt == 4'd0) open_string(acc[31:0]);
      end
      PARSE_PAYLOAD: begin
        w = blank_word(KIND_PAYLOAD);
        w.payload_byte = b;
        w.last_of_string = (payload_left == 32'd1);
        payload_left = payload_left - 32'd1;
        if (payload_left == 32'd0) phase = PARSE_PREV;
        decoded_words.push_back(w);
      end
      default: ;
    endcase
  endtask

  function automatic int field_diff(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    pld_result_t want;
    if (!rst_n) begin
      phase = PARSE_IDLE;
      byte_cnt = 4'd0;
      declared_cnt = 16'd0;
      seen_cnt = 16'd0;
      enc_byte = 8'd0;
      acc = 64'd0;
      payload_left = 32'd0;
      decoded_words.delete();
    end else begin
      // compare before predicting so a stray word never meets its own byte
      if (out_valid && !out_stall) begin
        if (decoded_words.size() == 0) begin
          $display("%0t: result word mismatch: expected none, actual kind %0d",
                   $time, out_kind);
          mismatches++;
        end else begin
          want = decoded_words.pop_front();
          mismatches += field_diff("kind", want.kind, out_kind);
          mismatches += field_diff("int_value", want.int_value, out_int_value);
          mismatches += field_diff("str_length", want.str_length, out_str_length);
          mismatches += field_diff("payload_byte", want.payload_byte, out_payload_byte);
          mismatches += field_diff("last_of_string", want.last_of_string,
                                   out_last_of_string);
          mismatches += field_diff("entry_count", want.entry_count, out_entry_count);
          mismatches += field_diff("count_error", want.count_error, out_count_error);
        end
      end
      if (in_valid && !in_stall) decode_byte(in_data_byte, in_start_req);
    end
    outstanding = decoded_words.size();
  end

endmodule

// ----- bench/packed_list_entry_decoder_test.sv -----
module packed_list_entry_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pld_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS   = 200;

  typedef enum logic [1:0] {STR6, STR14, STR32} str_form_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
  typedef enum logic [3:0] {
    ENTRY_INT8, ENTRY_INT16, ENTRY_INT24, ENTRY_INT32, ENTRY_INT64,
    ENTRY_IMM, ENTRY_OTHER, ENTRY_STR6, ENTRY_STR14, ENTRY_STR32
  } entry_kind_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_data_byte = 8'd0;
  logic               in_start_req = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_kind;
  logic signed [63:0] out_int_value;
  logic [31:0]        out_str_length;
  logic [7:0]         out_payload_byte;
  logic               out_last_of_string;
  logic [15:0]        out_entry_count;
  logic               out_count_error;
  int                 mismatches;
  int                 outstanding;

  logic [8:0]  list_words[$];
  int          header_at;
  int          list_entries;
  int          words_sent = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  packed_list_entry_decoder u_dut (.*);
  pld_entry_checker u_checker (.*);

  always #4 clk = ~clk;

  // receiver: switch between stall modes, each held for a random stall_left run
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 128);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_left % 12 < 5);
    endcase
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_byte(logic [7:0] b, logic st = 1'b0);
    list_words.push_back({st, b});
  endfunction

  // count bytes are patched in once the body is known
  function automatic void add_header();
    header_at = list_words.size();
    list_entries = 0;
    add_byte(rand_byte(), 1'b1);
    repeat (7) add_byte(rand_byte());
    repeat (2) add_byte(8'h00);
  endfunction

  function automatic void finish_list(logic [15:0] cnt);
    list_words[header_at + 8] = {1'b0, cnt[7:0]};
    list_words[header_at + 9] = {1'b0, cnt[15:8]};
    add_byte(END_MARK);
  endfunction

  function automatic void add_prev(logic long_form);
    list_entries++;
    if (long_form) begin
      add_byte(PREV_LONG);
      repeat (4) add_byte(rand_byte());
    end else begin
      add_byte(8'($urandom_range(0, 253)));
    end
  endfunction

  function automatic void add_int(logic [7:0] enc, int nbytes, logic [63:0] val);
    add_byte(enc);
    for (int i = 0; i < nbytes; i++) add_byte(val[8 * i +: 8]);
  endfunction

  function automatic void add_string(str_form_t form, logic [31:0] len, int n_payload);
    case (form)
      STR6: add_byte({2'b00, len[5:0]});
      STR14: begin
        add_byte({2'b01, len[13:8]});
        add_byte(len[7:0]);
      end
      default: begin
        add_byte({2'b10, 6'($urandom_range(0, 63))});
        add_byte(len[31:24]);
        add_byte(len[23:16]);
        add_byte(len[15:8]);
        add_byte(len[7:0]);
      end
    endcase
    repeat (n_payload) add_byte(rand_byte());
  endfunction

  function automatic void add_random_entry();
    entry_kind_t k;
    logic [63:0] v;
    int          len;
    int          r;
    v = {$urandom, $urandom};
    add_prev($urandom_range(0, 7) == 0);
    k = entry_kind_t'($urandom_range(0, 9));
    case (k)
      ENTRY_INT8:  add_int(ENC_INT8, 1, v);
      ENTRY_INT16: add_int(ENC_INT16, 2, v);
      ENTRY_INT24: add_int(ENC_INT24, 3, v);
      ENTRY_INT32: add_int(ENC_INT32, 4, v);
      ENTRY_INT64: add_int(ENC_INT64, 8, v);
      ENTRY_IMM: begin
        r = $urandom_range(1, 14);
        add_byte((r == 14) ? END_MARK : {4'hf, 4'(r)});
      end
      ENTRY_OTHER:
        add_byte({4'(4'hc + $urandom_range(0, 2)), 4'($urandom_range(1, 15))});
      ENTRY_STR6: begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
        add_string(STR6, len, len);
      end
      ENTRY_STR14: begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(64, 100) : $urandom_range(0, 5);
        add_string(STR14, len, len);
      end
      default: begin
        len = $urandom_range(0, 6);
        add_string(STR32, len, len);
      end
    endcase
  endfunction

  function automatic void build_random_list();
    add_header();
    repeat ($urandom_range(0, 8)) add_random_entry();
    finish_list(($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                             : 16'(list_entries));
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) add_byte(rand_byte());
  endfunction

  // entered and left at a falling edge
  task automatic send_word(logic [7:0] b, logic st);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_start_req <= st;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
    words_sent++;
  endtask

  task automatic send_list();
    foreach (list_words[i]) send_word(list_words[i][7:0], list_words[i][8]);
    list_words.delete();
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic run_directed();
    // drop: nothing started yet
    add_byte(END_MARK);
    add_byte(ENC_INT8);
    add_byte(8'h05);
    add_header();
    add_prev(1'b1);
    add_int(ENC_INT8, 1, 64'h80);
    add_prev(1'b0);
    add_int(ENC_INT8, 1, 64'h7f);
    add_prev(1'b0);
    add_int(ENC_INT16, 2, 64'h8000);
    add_prev(1'b0);
    add_int(ENC_INT16, 2, 64'h7fff);
    add_prev(1'b0);
    add_int(ENC_INT24, 3, 64'h80_0000);
    add_prev(1'b0);
    add_int(ENC_INT24, 3, 64'h7f_ffff);
    add_prev(1'b0);
    add_int(ENC_INT32, 4, 64'h8000_0000);
    add_prev(1'b0);
    add_int(ENC_INT32, 4, 64'h7fff_ffff);
    add_prev(1'b0);
    add_int(ENC_INT64, 8, 64'h8000_0000_0000_0000);
    add_prev(1'b0);
    add_int(ENC_INT64, 8, 64'h7fff_ffff_ffff_ffff);
    add_prev(1'b0);
    add_byte(8'hf1);
    add_prev(1'b0);
    add_byte(8'hfd);
    add_prev(1'b0);
    add_byte(END_MARK);
    add_prev(1'b0);
    add_byte(8'hc1);
    add_prev(1'b0);
    add_byte(8'hef);
    add_prev(1'b0);
    add_string(STR6, 0, 0);
    add_prev(1'b0);
    add_string(STR6, 63, 63);
    add_prev(1'b0);
    add_string(STR14, 0, 0);
    add_prev(1'b0);
    add_string(STR32, 1, 1);
    finish_list(16'(list_entries));
    // drop: past the end marker
    add_byte(ENC_INT8);
    add_byte(8'h00);
    add_byte(END_MARK);
    // header count the list never reaches
    add_header();
    add_prev(1'b0);
    add_int(ENC_INT64, 8, {$urandom, $urandom});
    add_prev(1'b0);
    add_string(STR14, 5, 5);
    finish_list(COUNT_MAX);
    // restart inside a huge string, then inside a header
    add_header();
    add_prev(1'b0);
    add_string(STR32, 32'hffff_ffff, 3);
    add_header();
    repeat (5) void'(list_words.pop_back());
    add_header();
    add_prev(1'b0);
    add_string(STR14, 32'd70, 70);
    add_prev(1'b0);
    add_byte(8'hf5);
    finish_list(16'd9);
    send_list();
    drain_results();
  endtask

  task automatic run_random();
    int first;
    int scenario;
    int lists;
    int cut;
    first = words_sent;
    lists = 0;
    while (words_sent - first < RANDOM_WORDS) begin
      scenario = $urandom_range(0, 9);
      if (scenario <= 6) begin
        build_random_list();
      end else if (scenario == 7) begin
        // truncate; the next start restarts the parse
        build_random_list();
        cut = $urandom_range(1, list_words.size() - 1);
        repeat (cut) void'(list_words.pop_back());
      end else if (scenario == 8) begin
        add_byte(rand_byte(), 1'b1);
        repeat ($urandom_range(0, 20)) add_byte(rand_byte());
      end else begin
        repeat ($urandom_range(1, 6)) add_byte(rand_byte());
      end
      send_list();
      lists++;
      if (lists == 4) drain_results();
    end
  endtask

  initial begin
    bit timed_out;
    int idle_cycles;
    timed_out = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    fork
      begin
        run_directed();
        run_random();
        drain_results();
        repeat (20) @(posedge clk);
      end
      begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
          @(posedge clk);
          if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
          else idle_cycles++;
        end
        timed_out = 1'b1;
      end
    join_any
    if (!timed_out && mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
